[hw/rtl/dq_pkg.sv]
// shared types and codes for the double-ended queue
package dq_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_REVERSE    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_PUSH_FULL  = 2'd1,
    ST_POP_EMPTY  = 2'd2
  } status_t;

  typedef logic [WORD_W-1:0] word_t;

endpackage

[hw/rtl/double_ended_queue_core.sv]
// double-ended queue: ring in a word memory, end words cached in registers
// results: pushes, reverse and rejected ops show theirs from the state registers; a pop that
// needs the new end word fetched from the memory waits in the fill state for the registered read port
// throughput: one transaction per cycle while results are taken; none while such a fetching pop waits
// reset: synchronous active-low, clears indices, count, direction and valid; memory
// contents are left as they are
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [2:0] action, [66:3] value, rest zero
  input  logic [71:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [63:0] front_word, [127:64] back_word, then entry_count, is_empty, status, zero pad
  output logic [((2*dq_pkg::WORD_W + $clog2(DEPTH+1) + 1 + dq_pkg::STATUS_W + 7)/8)*8-1:0]
               out_tdata
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned PAY_W = 2*dq_pkg::WORD_W + CW + 1 + dq_pkg::STATUS_W;
  localparam int unsigned OUT_W = ((PAY_W + 7)/8)*8;

  typedef enum logic {S_RUN, S_FILL} state_t;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    idx_inc = (i == AW'(DEPTH-1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    idx_dec = (i == '0) ? AW'(DEPTH-1) : i - 1'b1;
  endfunction

  state_t           state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             rev_r, rev_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fill_low_r, fill_low_nxt;
  dq_pkg::status_t  status_r, status_nxt;
  dq_pkg::word_t    low_r, low_nxt;
  dq_pkg::word_t    high_r, high_nxt;

  logic                  accept;
  logic [dq_pkg::ACTION_W-1:0] action;
  dq_pkg::word_t         value;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  dq_pkg::word_t         rd_data;
  logic                  at_low;
  dq_pkg::word_t         front_word, back_word;

  assign action    = in_tdata[dq_pkg::ACTION_W-1:0];
  assign value     = in_tdata[dq_pkg::ACTION_W +: dq_pkg::WORD_W];
  assign in_tready = (state_r == S_RUN) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  dq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    status_nxt    = status_r;
    fill_low_nxt  = fill_low_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    rd_addr       = head_r;
    at_low        = 1'b0;

    if (state_r == S_FILL) begin
      // new end word arrives from the memory
      if (fill_low_r) begin
        low_nxt = rd_data;
      end else begin
        high_nxt = rd_data;
      end
      state_nxt     = S_RUN;
      out_valid_nxt = 1'b1;
    end else if (accept) begin
      status_nxt    = dq_pkg::ST_DONE;
      out_valid_nxt = 1'b1;
      case (action)
        dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT: begin
          at_low = (action == dq_pkg::ACT_PUSH_FRONT) != rev_r;
          if (count_r == CW'(DEPTH)) begin
            status_nxt = dq_pkg::ST_PUSH_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (at_low) begin
              head_nxt = idx_dec(head_r);
              wr_addr  = idx_dec(head_r);
              low_nxt  = value;
              if (count_r == '0) high_nxt = value;
            end else begin
              tail_nxt = idx_inc(tail_r);
              wr_addr  = tail_r;
              high_nxt = value;
              if (count_r == '0) low_nxt = value;
            end
          end
        end
        dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
          at_low = (action == dq_pkg::ACT_POP_FRONT) != rev_r;
          if (count_r == '0) begin
            status_nxt = dq_pkg::ST_POP_EMPTY;
          end else begin
            count_nxt    = count_r - 1'b1;
            fill_low_nxt = at_low;
            if (at_low) begin
              head_nxt = idx_inc(head_r);
              rd_addr  = idx_inc(head_r);
            end else begin
              tail_nxt = idx_dec(tail_r);
              rd_addr  = idx_dec(idx_dec(tail_r));
            end
            if (count_r == CW'(2)) begin
              // single word left: both ends are the surviving cached word
              if (at_low) low_nxt = high_r;
              else        high_nxt = low_r;
            end else if (count_r > CW'(2)) begin
              state_nxt     = S_FILL;
              out_valid_nxt = 1'b0;
            end
          end
        end
        dq_pkg::ACT_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
      fill_low_r  <= 1'b0;
      status_r    <= dq_pkg::ST_DONE;
      low_r       <= '0;
      high_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      out_valid_r <= out_valid_nxt;
      fill_low_r  <= fill_low_nxt;
      status_r    <= status_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
    end
  end

  // results are shown from the state registers; no accept happens while one waits
  assign front_word = (count_r == '0) ? '0 : (rev_r ? high_r : low_r);
  assign back_word  = (count_r == '0) ? '0 : (rev_r ? low_r : high_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({status_r, (count_r == '0), count_r, back_word, front_word});

endmodule

[hw/rtl/dq_ram.sv]
// word store: one write port, one registered read port
module dq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  dq_pkg::word_t    wr_data,
  input  logic [AW-1:0]    rd_addr,
  output dq_pkg::word_t    rd_data
);

  dq_pkg::word_t mem [DEPTH];
  dq_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[test/testbench.sv]
// self-checking testbench for the double-ended queue core with random idling on both sides
module testbench;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned OUT_W      =
    ((2*dq_pkg::WORD_W + $clog2(DEPTH+1) + 1 + dq_pkg::STATUS_W + 7)/8)*8;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES     = 4;
  localparam int unsigned RAND_PER_PHASE = 100;

  typedef struct {
    logic [dq_pkg::ACTION_W-1:0] act;
    dq_pkg::word_t               value;
    bit                          drain;
    int unsigned                 phase;
  } deque_op_t;

  typedef struct {
    dq_pkg::word_t   front;
    dq_pkg::word_t   back;
    logic [6:0]      count;
    logic            empty;
    dq_pkg::status_t status;
  } deque_view_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [71:0]      in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  double_ended_queue_core #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle percentages per phase: none, sender, receiver, both
  int unsigned sender_idle_pct [PHASES] = '{0, 82, 0, 38};
  int unsigned recv_stall_pct  [PHASES] = '{0, 0, 82, 38};

  deque_op_t   pending_ops[$];
  deque_view_t expected_views[$];

  // shadow of the deque state
  dq_pkg::word_t ring [DEPTH];
  int unsigned head_slot = 0;
  int unsigned tail_slot = 0;
  int unsigned fill = 0;
  bit          flipped = 1'b0;

  int unsigned phase_now = 0;
  int unsigned ops_sent = 0;
  int unsigned views_got = 0;
  int unsigned errors = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned peak_fill = 0;
  int unsigned quiet_cycles = 0;

  function automatic deque_view_t deque_apply(logic [dq_pkg::ACTION_W-1:0] act,
                                              dq_pkg::word_t value);
    deque_view_t   v;
    bit            at_low;
    dq_pkg::word_t low_w;
    dq_pkg::word_t high_w;
    v.status = dq_pkg::ST_DONE;
    low_w = '0;
    high_w = '0;
    case (act)
      dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          v.status = dq_pkg::ST_PUSH_FULL;
          full_rejects++;
        end else begin
          at_low = (act == dq_pkg::ACT_PUSH_FRONT) != flipped;
          if (at_low) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring[head_slot] = value;
          end else begin
            ring[tail_slot] = value;
            tail_slot = (tail_slot + 1) % DEPTH;
          end
          fill++;
        end
      end
      dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
        if (fill == 0) begin
          v.status = dq_pkg::ST_POP_EMPTY;
          empty_rejects++;
        end else begin
          at_low = (act == dq_pkg::ACT_POP_FRONT) != flipped;
          if (at_low) head_slot = (head_slot + 1) % DEPTH;
          else tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
          fill--;
        end
      end
      dq_pkg::ACT_REVERSE: flipped = !flipped;
      default: ;
    endcase
    if (fill != 0) begin
      low_w = ring[head_slot];
      high_w = ring[(tail_slot + DEPTH - 1) % DEPTH];
    end
    if (fill > peak_fill) peak_fill = fill;
    v.front = flipped ? high_w : low_w;
    v.back  = flipped ? low_w : high_w;
    v.count = fill[6:0];
    v.empty = (fill == 0);
    return v;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver: offers the oldest pending op, holds it until the transaction completes
  always @(posedge clk) begin
    bit        accepted;
    bit        drained;
    bit        go;
    deque_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      accepted = in_tvalid && in_tready;
      if (accepted) begin
        op = pending_ops.pop_front();
        expected_views.push_back(deque_apply(op.act, op.value));
        ops_sent <= ops_sent + 1;
      end
      if (!(in_tvalid && !in_tready)) begin
        go = 1'b0;
        if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          drained = !accepted && (ops_sent == views_got);
          go = (!op.drain || drained) &&
               ($urandom_range(99) >= sender_idle_pct[op.phase]);
          if (go) begin
            in_tdata  <= {5'b0, op.value, op.act};
            phase_now <= op.phase;
          end
        end
        in_tvalid <= go;
      end
    end
  end

  // monitor: compares every result transaction with the oldest expectation
  always @(posedge clk) begin
    deque_view_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        views_got <= views_got + 1;
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_views.pop_front();
          check_field("front_word", want.front, out_tdata[63:0]);
          check_field("back_word", want.back, out_tdata[127:64]);
          check_field("entry_count", 64'(want.count), 64'(out_tdata[134:128]));
          check_field("is_empty", 64'(want.empty), 64'(out_tdata[135]));
          check_field("status", 64'(want.status), 64'(out_tdata[137:136]));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct[phase_now]);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("double_ended_queue_core regression: fail");
        $finish;
      end
    end
  end

  task automatic add_op(logic [dq_pkg::ACTION_W-1:0] act, dq_pkg::word_t value, bit drain,
                        int unsigned phase);
    deque_op_t op;
    op.act = act;
    op.value = value;
    op.drain = drain;
    op.phase = phase;
    pending_ops.push_back(op);
  endtask

  initial begin
    int unsigned  push_bias [6];
    int unsigned  k;
    int unsigned  r;
    int unsigned  bias;
    logic [dq_pkg::ACTION_W-1:0] act;
    dq_pkg::word_t value;

    push_bias = '{95, 95, 5, 5, 50, 50};

    // directed: empty rejects, reverse on empty, extremes, unused codes, reversed ends
    add_op(dq_pkg::ACT_POP_FRONT, '1, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_BACK, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_REVERSE, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_REVERSE, '1, 1'b0, 0);
    add_op(dq_pkg::ACT_PUSH_BACK, '1, 1'b0, 0);
    add_op(dq_pkg::ACT_PUSH_FRONT, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_PUSH_BACK, {16{4'h5}}, 1'b0, 0);
    add_op(dq_pkg::ACT_PUSH_FRONT, {16{4'hA}}, 1'b0, 0);
    add_op(3'd5, '1, 1'b0, 0);
    add_op(3'd6, {16{4'h5}}, 1'b0, 0);
    add_op(3'd7, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_REVERSE, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_PUSH_BACK, 64'h8000_0000_0000_0001, 1'b0, 0);
    add_op(dq_pkg::ACT_PUSH_FRONT, 64'h7fff_ffff_ffff_fffe, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_FRONT, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_BACK, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_REVERSE, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_FRONT, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_BACK, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_FRONT, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_BACK, '0, 1'b0, 0);
    add_op(dq_pkg::ACT_POP_FRONT, '1, 1'b0, 0);

    // random: blocks alternate between filling, draining and mixed traffic
    for (k = 0; k < PHASES * RAND_PER_PHASE; k++) begin
      bias = push_bias[(k / 45) % 6];
      r = $urandom_range(99);
      case ($urandom_range(7))
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      if (r < 3) act = 3'($urandom_range(7, 5));
      else if (r < 10) act = dq_pkg::ACT_REVERSE;
      else if ($urandom_range(99) < bias)
        act = $urandom_range(1) ? dq_pkg::ACT_PUSH_FRONT : dq_pkg::ACT_PUSH_BACK;
      else act = $urandom_range(1) ? dq_pkg::ACT_POP_FRONT : dq_pkg::ACT_POP_BACK;
      // each phase starts only after every result of the previous one has been received
      add_op(act, value, (k % RAND_PER_PHASE) == 0, k / RAND_PER_PHASE);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_ops.size() > 0 || in_tvalid || expected_views.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d operations in %0d idling phases, %0d results checked",
             ops_sent, PHASES, views_got);
    $display("peak fill %0d of %0d, %0d full pushes and %0d empty pops rejected",
             peak_fill, DEPTH, full_rejects, empty_rejects);
    if (errors == 0) begin
      $display("double_ended_queue_core regression: pass");
    end else begin
      $display("double_ended_queue_core regression: fail");
    end
    $finish;
  end

endmodule
